// ----- hdl/lcms_pkg.sv -----
`default_nettype none

package lcms_pkg;

	// geometry of the row store and the cost words
	localparam int MAX_COLS      = 1024;
	localparam int COL_BITS      = $clog2(MAX_COLS);
	localparam int COLCNT_BITS   = 11;
	localparam int ROW_BITS      = 16;
	localparam int COST_BITS     = 48;
	localparam int DIST_BITS     = 32;

	// sqrt2 weight, unsigned Q1.16
	localparam int SQRT2_BITS    = 17;
	localparam logic [SQRT2_BITS-1:0] SQRT2_Q16 = 17'd92682;
	localparam int PROD_BITS     = DIST_BITS + SQRT2_BITS;
	localparam int WDIST_BITS    = PROD_BITS - 16;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int MODE_BITS     = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PATH_MODE = 2'd2;

	// predecessor selection
	localparam logic [MODE_BITS-1:0] MODE_ORTHO = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_DIAG  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_SQRT2 = 2'd2;

	typedef logic [COST_BITS-1:0] cost_t;

	// position flags of one cell
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last;
	} cell_ctl_t;

	// saturating add of two costs
	function automatic cost_t sat_add(input cost_t a, input cost_t b);
		logic [COST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_BITS] ? '1 : s[COST_BITS-1:0];
	endfunction

	function automatic cost_t min_cost(input cost_t a, input cost_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/lcms_row_store.sv -----
`default_nettype none

module lcms_row_store (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [lcms_pkg::COL_BITS-1:0] wr_addr,
	input  wire lcms_pkg::cost_t         wr_data,
	input  wire logic                    rd_en,
	input  wire logic [lcms_pkg::COL_BITS-1:0] rd_addr,
	output lcms_pkg::cost_t              rd_data
);
	import lcms_pkg::*;

	cost_t mem [MAX_COLS];
	cost_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, new data passed through when the same column is written now
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/lcms_cell_calc.sv -----
`default_nettype none

module lcms_cell_calc (
	input  wire logic [lcms_pkg::MODE_BITS-1:0]  path_mode,
	input  wire lcms_pkg::cell_ctl_t             ctl,
	input  wire logic [lcms_pkg::DIST_BITS-1:0]  cell_dist,
	input  wire logic [lcms_pkg::WDIST_BITS-1:0] wdist,
	input  wire lcms_pkg::cost_t                 up_cost,
	input  wire lcms_pkg::cost_t                 left_cost,
	input  wire lcms_pkg::cost_t                 diag_cost,
	input  wire lcms_pkg::cost_t                 origin_cost,
	output lcms_pkg::cost_t                      cell_cost,
	output lcms_pkg::cost_t                      out_cost
);
	import lcms_pkg::*;

	cost_t d_ext;
	cost_t wd_ext;
	cost_t min_ul;
	cost_t origin_use;

	assign d_ext  = COST_BITS'(cell_dist);
	assign wd_ext = COST_BITS'(wdist);
	assign min_ul = min_cost(up_cost, left_cost);

	// least predecessor plus distance
	always_comb begin
		if (ctl.first_row && ctl.first_col) begin
			cell_cost = d_ext;
		end else if (ctl.first_row) begin
			cell_cost = sat_add(left_cost, d_ext);
		end else if (ctl.first_col) begin
			cell_cost = sat_add(up_cost, d_ext);
		end else begin
			case (path_mode)
				MODE_DIAG: cell_cost = sat_add(min_cost(min_ul, diag_cost), d_ext);
				MODE_SQRT2: cell_cost = min_cost(sat_add(min_ul, d_ext),
					sat_add(diag_cost, wd_ext));
				default: cell_cost = sat_add(min_ul, d_ext);
			endcase
		end
	end

	// final cell closes the path through the origin
	assign origin_use = (ctl.first_row && ctl.first_col) ? cell_cost : origin_cost;
	assign out_cost   = ctl.last ? sat_add(cell_cost, origin_use) : cell_cost;

endmodule

`default_nettype wire

// ----- hdl/least_cost_matrix_stream.sv -----
`default_nettype none

// channel   direction  handshake            payload
// in        to block   in_valid / in_stall   dist_value
// out       from block out_valid / out_stall cost_value, last_cell
// cfg       to block   cfg_write             cfg_index, cfg_data
//
// One cell per cycle sustained unless out_stall holds the flow; a cell passes the input
// stage register, then the result register, and its output transfer follows from there.
// The row store read is issued at the input transfer, so the previous row's cost is
// ready while the cell sits in the input stage; same-column writes are forwarded.
// Reset clears counters, running costs and valid flags; the row store holds no reset.
// A stall on the output holds the result register and backs up into in_stall.
module least_cost_matrix_stream (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [lcms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [lcms_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [lcms_pkg::DIST_BITS-1:0]       dist_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [lcms_pkg::COST_BITS-1:0]            cost_value,
	output logic                                      last_cell
);
	import lcms_pkg::*;

	logic [ROW_BITS-1:0]    row_count_q;
	logic [COLCNT_BITS-1:0] col_count_q;
	logic [MODE_BITS-1:0]   path_mode_q;
	logic                   restart;

	logic [ROW_BITS-1:0]    row_q;
	logic [COL_BITS-1:0]    col_q;
	logic [ROW_BITS-1:0]    rows_eff;
	logic [COLCNT_BITS-1:0] cols_eff;
	logic                   col_end;
	logic                   job_end;

	logic                   in_xfer;
	logic                   s1_move;
	logic                   valid_s1;
	cell_ctl_t              ctl_s1;
	logic [COL_BITS-1:0]    col_s1;
	logic [DIST_BITS-1:0]   dist_s1;
	logic [WDIST_BITS-1:0]  wdist_s1;
	logic [PROD_BITS-1:0]   prod;

	cost_t                  left_q;
	cost_t                  diag_q;
	cost_t                  origin_q;
	cost_t                  rd_cost;
	cost_t                  up_cost;
	cost_t                  cell_cost;
	cost_t                  out_cost;

	logic                   out_valid_q;
	cost_t                  cost_q;
	logic                   last_q;

	// configuration registers, any accepted write restarts the job
	assign restart = cfg_write && ((cfg_index == REG_ROW_COUNT) ||
		(cfg_index == REG_COL_COUNT) || (cfg_index == REG_PATH_MODE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_BITS'(1);
			col_count_q <= COLCNT_BITS'(1);
			path_mode_q <= MODE_ORTHO;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data[ROW_BITS-1:0];
				REG_COL_COUNT: col_count_q <= cfg_data[COLCNT_BITS-1:0];
				REG_PATH_MODE: path_mode_q <= cfg_data[MODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// effective job shape
	always_comb begin
		rows_eff = (row_count_q == '0) ? ROW_BITS'(1) : row_count_q;
		if (col_count_q == '0) begin
			cols_eff = COLCNT_BITS'(1);
		end else if (col_count_q > COLCNT_BITS'(MAX_COLS)) begin
			cols_eff = COLCNT_BITS'(MAX_COLS);
		end else begin
			cols_eff = col_count_q;
		end
	end

	assign col_end = ((COLCNT_BITS'(col_q) + COLCNT_BITS'(1)) >= cols_eff);
	assign job_end = col_end &&
		(({1'b0, row_q} + (ROW_BITS+1)'(1)) >= {1'b0, rows_eff});

	// handshake: input stage advances when the result register is free
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign in_xfer  = in_valid && !in_stall;

	// cell position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_xfer) begin
			if (job_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_end) begin
				row_q <= row_q + ROW_BITS'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

	// weighted distance, formed ahead of the input register
	assign prod = PROD_BITS'(dist_value) * PROD_BITS'(SQRT2_Q16);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ctl_s1.first_row <= (row_q == '0);
			ctl_s1.first_col <= (col_q == '0);
			ctl_s1.last      <= job_end;
			col_s1           <= col_q;
			dist_s1          <= dist_value;
			wdist_s1         <= prod[PROD_BITS-1:16];
		end
	end

	// previous row costs
	lcms_row_store u_row_store (
		.clk     (clk),
		.wr_en   (s1_move),
		.wr_addr (col_s1),
		.wr_data (cell_cost),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (rd_cost)
	);

	assign up_cost = ctl_s1.first_row ? '0 : rd_cost;

	lcms_cell_calc u_cell_calc (
		.path_mode   (path_mode_q),
		.ctl         (ctl_s1),
		.cell_dist   (dist_s1),
		.wdist       (wdist_s1),
		.up_cost     (up_cost),
		.left_cost   (left_q),
		.diag_cost   (diag_q),
		.origin_cost (origin_q),
		.cell_cost   (cell_cost),
		.out_cost    (out_cost)
	);

	// running costs, updated as each cell leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			diag_q   <= '0;
			origin_q <= '0;
		end else if (restart) begin
			left_q   <= '0;
			diag_q   <= '0;
			origin_q <= '0;
		end else if (s1_move) begin
			left_q <= cell_cost;
			diag_q <= up_cost;
			if (ctl_s1.first_row && ctl_s1.first_col) begin
				origin_q <= cell_cost;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			cost_q <= out_cost;
			last_q <= ctl_s1.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign cost_value = cost_q;
	assign last_cell  = last_q;

endmodule

`default_nettype wire

// ----- tb/tb_least_cost_matrix_stream.sv -----
module tb_least_cost_matrix_stream;
	import lcms_pkg::*;

	localparam int          LIMIT_CYCLES = 1_500_000;
	localparam int          PHASE_CELLS  = 200;
	localparam logic [63:0] SQRT2_WEIGHT = 64'd92682;
	// mode 3 has no name in the package; it falls back to the orthogonal path
	localparam logic [MODE_BITS-1:0]    MODE_SPARE = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE   = 2'd3;

	typedef struct packed {
		logic [COST_BITS-1:0] cost;
		logic                 is_last;
	} cell_result_t;

	typedef struct packed {
		logic                    is_cfg;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0] data;
		logic [DIST_BITS-1:0]    dist_in;
		logic                    typed;
		logic [COST_BITS-1:0]    want_cost;
		logic                    want_last;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [DIST_BITS-1:0]     dist_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [COST_BITS-1:0]     cost_value;
	logic                     last_cell;

	least_cost_matrix_stream dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.dist_value (dist_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cost_value (cost_value),
		.last_cell  (last_cell)
	);

	// clock, period 4
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// costs still owed by the block, oldest first
	cell_result_t pending_costs[$];
	cell_result_t head;

	int cycle_count     = 0;
	int mismatch_count  = 0;
	int cells_sent      = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;

	// predicted block state
	cost_t        prev_row [MAX_COLS];
	cost_t        left_acc;
	cost_t        diag_acc;
	cost_t        origin_acc;
	int unsigned  cur_row;
	int unsigned  cur_col;
	logic [ROW_BITS-1:0]    rows_cfg;
	logic [COLCNT_BITS-1:0] cols_cfg;
	logic [MODE_BITS-1:0]   mode_cfg;

	task automatic report_mismatch(input string what, input logic [COST_BITS-1:0] got,
			input logic [COST_BITS-1:0] want);
		$display("mismatch at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	function automatic cost_t add_clamped(input cost_t a, input cost_t b);
		logic [COST_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_BITS] ? {COST_BITS{1'b1}} : s[COST_BITS-1:0];
	endfunction

	function automatic cost_t lesser(input cost_t a, input cost_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic void restart_path();
		left_acc   = '0;
		diag_acc   = '0;
		origin_acc = '0;
		cur_row    = 0;
		cur_col    = 0;
	endfunction

	// least cost of the next cell in row-major order, advancing the position
	function automatic cell_result_t predict_cell(input logic [DIST_BITS-1:0] d);
		int unsigned  rows;
		int unsigned  cols;
		int unsigned  c;
		cost_t        up;
		cost_t        dist_ext;
		cost_t        cost;
		cost_t        wdist;
		logic [63:0]  prod;
		logic         row_end;
		logic         is_last;
		cell_result_t r;
		rows = (rows_cfg == 0) ? 1 : rows_cfg;
		cols = (cols_cfg == 0) ? 1 : cols_cfg;
		if (cols > MAX_COLS)
			cols = MAX_COLS;
		if (cur_col >= cols)
			cur_col = 0;
		c        = cur_col;
		dist_ext = {{(COST_BITS-DIST_BITS){1'b0}}, d};
		up       = (cur_row != 0) ? prev_row[c] : '0;

		if (cur_row == 0 && c == 0) begin
			cost       = dist_ext;
			origin_acc = cost;
		end else if (cur_row == 0) begin
			cost = add_clamped(left_acc, dist_ext);
		end else if (c == 0) begin
			cost = add_clamped(up, dist_ext);
		end else begin
			case (mode_cfg)
				MODE_DIAG: begin
					cost = add_clamped(lesser(lesser(up, left_acc), diag_acc), dist_ext);
				end
				MODE_SQRT2: begin
					prod  = {32'd0, d} * SQRT2_WEIGHT;
					wdist = prod[63:16];
					cost  = lesser(add_clamped(lesser(up, left_acc), dist_ext),
						add_clamped(diag_acc, wdist));
				end
				default: begin
					cost = add_clamped(lesser(up, left_acc), dist_ext);
				end
			endcase
		end

		diag_acc    = up;
		left_acc    = cost;
		prev_row[c] = cost;

		// final cell also carries the origin cost
		row_end = (c + 1 >= cols);
		is_last = row_end && (cur_row + 1 >= rows);
		if (is_last)
			cost = add_clamped(cost, origin_acc);

		if (is_last) begin
			cur_row = 0;
			cur_col = 0;
		end else if (row_end) begin
			cur_row = (cur_row + 1) & 32'hFFFF;
			cur_col = 0;
		end else begin
			cur_col = c + 1;
		end
		r.cost    = cost;
		r.is_last = is_last;
		return r;
	endfunction

	// one cell transfer, with the expected cost queued first
	task automatic send_cell(input logic [DIST_BITS-1:0] d, input logic typed,
			input logic [COST_BITS-1:0] want_cost, input logic want_last);
		cell_result_t r;
		r = predict_cell(d);
		if (typed) begin
			r.cost    = want_cost;
			r.is_last = want_last;
		end
		pending_costs.push_back(r);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		dist_value <= d;
		do
			@(posedge clk);
		while (in_stall);
		cells_sent++;
	endtask

	// stop sending and let the block empty out
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_costs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		reg_writes++;
		// unknown index changes nothing, not even the position
		case (idx)
			REG_ROW_COUNT: begin
				rows_cfg = data;
				restart_path();
			end
			REG_COL_COUNT: begin
				cols_cfg = data[COLCNT_BITS-1:0];
				restart_path();
			end
			REG_PATH_MODE: begin
				mode_cfg = data[MODE_BITS-1:0];
				restart_path();
			end
			default: ;
		endcase
	endtask

	function automatic logic [DIST_BITS-1:0] rand_dist();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom;
			4:       return {16'($urandom_range(16'hFFFF, 16'hFFF0)), 16'($urandom)};
			default: return $urandom_range(32'h000F_FFFF);
		endcase
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		dir_row_t r;
		r        = '0;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic dir_row_t cell_row(input logic [DIST_BITS-1:0] d);
		dir_row_t r;
		r         = '0;
		r.dist_in = d;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic [DIST_BITS-1:0] d,
			input logic [COST_BITS-1:0] cost, input logic is_last);
		dir_row_t r;
		r           = cell_row(d);
		r.typed     = 1'b1;
		r.want_cost = cost;
		r.want_last = is_last;
		return r;
	endfunction

	// result side: check every output transfer, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_costs.size() == 0) begin
					report_mismatch("unexpected result, cost_value", cost_value, '0);
				end else begin
					head = pending_costs.pop_front();
					if (cost_value !== head.cost)
						report_mismatch("cost_value", cost_value, head.cost);
					if (last_cell !== head.is_last)
						report_mismatch("last_cell", COST_BITS'(last_cell),
							COST_BITS'(head.is_last));
					results_checked++;
				end
			end
			out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d costs still owed", cycle_count,
				pending_costs.size());
			$display("least_cost_matrix_stream verification failed");
			$finish;
		end
	end

	initial begin
		dir_row_t    dir_tab[$];
		int          phase_start;
		int unsigned rows_eff;
		int unsigned cols_eff;
		int unsigned n_cells;

		// state after reset
		rows_cfg = 16'd1;
		cols_cfg = 11'd1;
		mode_cfg = MODE_ORTHO;
		restart_path();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single cells, a diagonal job, a weighted job cut short,
		// a spare-mode job across an ignored write, zero counts
		dir_tab = '{
			known_row(32'd5, 48'd10, 1'b1),
			known_row(32'hFFFF_FFFF, 48'h1_FFFF_FFFE, 1'b1),
			known_row(32'd0, 48'd0, 1'b1),
			cfg_row(REG_ROW_COUNT, 16'd2),
			cfg_row(REG_COL_COUNT, 16'd3),
			cfg_row(REG_PATH_MODE, {14'd0, MODE_DIAG}),
			cell_row(32'd1), cell_row(32'hFFFF_FFFF), cell_row(32'd0),
			cell_row(32'd3), cell_row(32'd2), cell_row(32'd4),
			cfg_row(REG_PATH_MODE, {14'd0, MODE_SQRT2}),
			cell_row(32'h0001_0000), cell_row(32'h0001_0000), cell_row(32'h0001_0000),
			cell_row(32'h0001_0000), cell_row(32'hFFFF_FFFF), cell_row(32'h0003_0007),
			cell_row(32'd9), cell_row(32'd11),
			cfg_row(REG_PATH_MODE, {14'd0, MODE_SPARE}),
			cell_row(32'd8), cell_row(32'd1), cell_row(32'd6), cell_row(32'd2),
			cfg_row(REG_NONE, 16'hFFFF),
			cell_row(32'd1), cell_row(32'd5),
			cfg_row(REG_ROW_COUNT, 16'd0),
			cfg_row(REG_COL_COUNT, 16'd0),
			known_row(32'd7, 48'd14, 1'b1)
		};
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle_block();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_cell(dir_tab[i].dist_in, dir_tab[i].typed, dir_tab[i].want_cost,
					dir_tab[i].want_last);
			end
		end

		// random jobs under four idling patterns
		for (int phase = 0; phase < 4; phase++) begin
			settle_block();
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			phase_start = cells_sent;
			while (cells_sent - phase_start < PHASE_CELLS) begin
				settle_block();
				// new job shape, upper data bits random
				if ($urandom_range(3) != 0) begin
					case ($urandom_range(9))
						0:       write_reg(REG_ROW_COUNT, 16'd0);
						1:       write_reg(REG_ROW_COUNT, 16'($urandom));
						default: write_reg(REG_ROW_COUNT, 16'($urandom_range(6, 1)));
					endcase
				end
				if ($urandom_range(3) != 0) begin
					case ($urandom_range(9))
						0:       write_reg(REG_COL_COUNT, {5'($urandom), 11'd0});
						1:       write_reg(REG_COL_COUNT,
							{5'($urandom), 11'($urandom_range(2047, 1025))});
						default: write_reg(REG_COL_COUNT,
							{5'($urandom), 11'($urandom_range(8, 1))});
					endcase
				end
				if ($urandom_range(3) != 0)
					write_reg(REG_PATH_MODE, {14'($urandom), 2'($urandom_range(3))});
				if ($urandom_range(9) == 0)
					write_reg(REG_NONE, 16'($urandom));

				rows_eff = (rows_cfg == 0) ? 1 : rows_cfg;
				cols_eff = (cols_cfg == 0) ? 1 : cols_cfg;
				if (cols_eff > MAX_COLS)
					cols_eff = MAX_COLS;
				// whole jobs mostly, sometimes a job broken off partway
				if (rows_eff * cols_eff > 64) begin
					n_cells = $urandom_range(64, 1);
				end else begin
					n_cells = rows_eff * cols_eff * $urandom_range(3, 1);
					if ($urandom_range(4) == 0)
						n_cells += $urandom_range(rows_eff * cols_eff, 1);
				end
				repeat (n_cells) send_cell(rand_dist(), 1'b0, '0, 1'b0);
			end

			if (phase == 0) begin
				// column count past the row store depth, clamped to it;
				// the start of the second row reads the first row back
				settle_block();
				write_reg(REG_ROW_COUNT, 16'd2);
				write_reg(REG_COL_COUNT, 16'h07FF);
				write_reg(REG_PATH_MODE, {14'd0, 2'($urandom_range(2))});
				repeat (MAX_COLS + 8) send_cell(rand_dist(), 1'b0, '0, 1'b0);
			end
		end

		settle_block();
		repeat (8) @(posedge clk);

		$display("%0d cells sent in directed and random jobs under four idling patterns,",
			cells_sent);
		$display("%0d costs checked, %0d register writes", results_checked, reg_writes);
		if (mismatch_count == 0 && pending_costs.size() == 0) begin
			$display("least_cost_matrix_stream verification clean");
		end else begin
			$display("least_cost_matrix_stream verification failed");
		end
		$finish;
	end

endmodule
